>>> hw/rtl/palette_indexed_framebuffer_assert.svh
// assertion macros for the checker file
`ifndef PALETTE_INDEXED_FRAMEBUFFER_ASSERT_SVH
`define PALETTE_INDEXED_FRAMEBUFFER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PIF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PIF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/pif_pkg.sv
package pif_pkg;

  localparam int AREA_WIDTH   = 128;
  localparam int AREA_HEIGHT  = 64;
  localparam int PALETTE_SIZE = 16;

  localparam int STORE_BYTES = (AREA_WIDTH * AREA_HEIGHT + 1) / 2;
  localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
  localparam int PAL_AW      = $clog2(PALETTE_SIZE);
  localparam int CNT_W       = $clog2(PALETTE_SIZE + 1);

  // widths wide enough for the largest area allowed
  localparam int CMP_W = 11;
  localparam int OFF_W = 21;
  localparam int IDX_W = 5;

  localparam logic [15:0] BLACK = 16'h0000;

  typedef enum logic [1:0] {
    CMD_WRITE   = 2'd0,
    CMD_READ    = 2'd1,
    CMD_PALETTE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

endpackage

>>> hw/rtl/pif_ram.sv
module pif_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/palette_indexed_framebuffer.sv
// 4bpp indexed framebuffer with an rgb565 palette; results cannot be held off
// a read fetches the pixel byte, then its palette entry, and strobes the registered result
// write, read and clear hold busy until done; a palette beat is written in its accept cycle;
//   write reads the pixel byte then writes it back, clear writes every pixel byte in turn
// reset: synchronous, active low; clears fsm, palette count and strobe only,
//   pixel and palette memories hold no defined data until written (no clearing pass)
module palette_indexed_framebuffer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_command,
  input  logic [6:0]  in_x,
  input  logic [5:0]  in_y,
  input  logic [3:0]  in_color_index,
  input  logic [15:0] in_palette_color,
  output logic        out_valid,
  output logic [3:0]  out_stored_index,
  output logic [15:0] out_pixel_color
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WR_MOD,
    ST_RD_PIX,
    ST_RD_PAL,
    ST_CLEAR
  } state_t;

  // control state
  state_t                       state_r,     state_nxt;
  logic [pif_pkg::CNT_W-1:0]    count_r,     count_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // payload held across the multi-cycle commands
  logic [pif_pkg::ADDR_W-1:0]   addr_r,      addr_nxt;
  logic                         odd_r,       odd_nxt;
  logic                         oor_r,       oor_nxt;
  logic [3:0]                   ci_r,        ci_nxt;
  logic [3:0]                   idx_r,       idx_nxt;
  logic [3:0]                   out_idx_r,   out_idx_nxt;
  logic [15:0]                  out_col_r,   out_col_nxt;

  // memory ports
  logic                         pix_we;
  logic [pif_pkg::ADDR_W-1:0]   pix_waddr;
  logic [7:0]                   pix_wdata;
  logic [pif_pkg::ADDR_W-1:0]   pix_raddr;
  logic [7:0]                   pix_rdata;
  logic                         pal_we;
  logic [pif_pkg::PAL_AW-1:0]   pal_raddr;
  logic [15:0]                  pal_rdata;

  // decode of the incoming beat
  logic                         accept;
  pif_pkg::cmd_t                cmd;
  logic                         in_range;
  logic [pif_pkg::OFF_W-1:0]    offset;
  logic                         pal_ok;
  logic [3:0]                   rd_idx;

  assign accept = start && (state_r == ST_IDLE);
  assign cmd    = pif_pkg::cmd_t'(in_command);

  // coordinates compared at a width that holds any allowed area size
  assign in_range = (pif_pkg::CMP_W'(in_x) < pif_pkg::CMP_W'(pif_pkg::AREA_WIDTH)) &&
                    (pif_pkg::CMP_W'(in_y) < pif_pkg::CMP_W'(pif_pkg::AREA_HEIGHT));

  // pixel offset y*width+x, multiply by a constant
  assign offset = pif_pkg::OFF_W'(in_y) * pif_pkg::OFF_W'(pif_pkg::AREA_WIDTH) +
                  pif_pkg::OFF_W'(in_x);

  // palette entries past the table size are ignored
  assign pal_ok = pif_pkg::IDX_W'(in_color_index) < pif_pkg::IDX_W'(pif_pkg::PALETTE_SIZE);

  // nibble pick from the byte that came back; even pixel in the low nibble
  assign rd_idx = oor_r ? 4'd0 : (odd_r ? pix_rdata[7:4] : pix_rdata[3:0]);

  // pixel memory: read in the accept cycle, written back in the modify cycle or by clear
  always_comb begin
    pix_raddr = offset[pif_pkg::ADDR_W:1];
    pix_we    = 1'b0;
    pix_waddr = addr_r;
    pix_wdata = {ci_r, ci_r};
    case (state_r)
      ST_WR_MOD: begin
        pix_we    = !oor_r;
        pix_wdata = odd_r ? {ci_r, pix_rdata[3:0]} : {pix_rdata[7:4], ci_r};
      end
      ST_CLEAR: begin
        pix_we = 1'b1;
      end
      default: begin
        pix_we = 1'b0;
      end
    endcase
  end

  // palette memory: written straight from the beat, read with the fetched index
  assign pal_we    = accept && (cmd == pif_pkg::CMD_PALETTE) && pal_ok;
  assign pal_raddr = rd_idx[pif_pkg::PAL_AW-1:0];

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    addr_nxt      = addr_r;
    odd_nxt       = odd_r;
    oor_nxt       = oor_r;
    ci_nxt        = ci_r;
    idx_nxt       = idx_r;
    out_idx_nxt   = out_idx_r;
    out_col_nxt   = out_col_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          addr_nxt = offset[pif_pkg::ADDR_W:1];
          odd_nxt  = offset[0];
          oor_nxt  = !in_range;
          ci_nxt   = in_color_index;
          case (cmd)
            pif_pkg::CMD_WRITE: begin
              state_nxt = ST_WR_MOD;
            end
            pif_pkg::CMD_READ: begin
              state_nxt = ST_RD_PIX;
            end
            pif_pkg::CMD_PALETTE: begin
              // count grows to cover the highest entry set so far
              if (pal_ok && (pif_pkg::IDX_W'(in_color_index) >= pif_pkg::IDX_W'(count_r))) begin
                count_nxt = pif_pkg::CNT_W'(pif_pkg::IDX_W'(in_color_index) + 5'd1);
              end
            end
            pif_pkg::CMD_CLEAR: begin
              addr_nxt  = '0;
              state_nxt = ST_CLEAR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_WR_MOD: begin
        state_nxt = ST_IDLE;
      end
      ST_RD_PIX: begin
        idx_nxt   = rd_idx;
        state_nxt = ST_RD_PAL;
      end
      ST_RD_PAL: begin
        out_valid_nxt = 1'b1;
        out_idx_nxt   = idx_r;
        // black for off-area reads and for indexes past the used count
        if (!oor_r && (pif_pkg::IDX_W'(idx_r) < pif_pkg::IDX_W'(count_r))) begin
          out_col_nxt = pal_rdata;
        end else begin
          out_col_nxt = pif_pkg::BLACK;
        end
        state_nxt = ST_IDLE;
      end
      ST_CLEAR: begin
        addr_nxt = addr_r + pif_pkg::ADDR_W'(1);
        if (addr_r == pif_pkg::ADDR_W'(pif_pkg::STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    addr_r    <= addr_nxt;
    odd_r     <= odd_nxt;
    oor_r     <= oor_nxt;
    ci_r      <= ci_nxt;
    idx_r     <= idx_nxt;
    out_idx_r <= out_idx_nxt;
    out_col_r <= out_col_nxt;
  end

  // packed pixel bytes, two pixels per entry
  pif_ram #(
    .WIDTH (8),
    .DEPTH (pif_pkg::STORE_BYTES)
  ) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (pix_waddr),
    .wdata (pix_wdata),
    .raddr (pix_raddr),
    .rdata (pix_rdata)
  );

  // rgb565 palette entries
  pif_ram #(
    .WIDTH (16),
    .DEPTH (pif_pkg::PALETTE_SIZE)
  ) u_pal_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_color_index[pif_pkg::PAL_AW-1:0]),
    .wdata (in_palette_color),
    .raddr (pal_raddr),
    .rdata (pal_rdata)
  );

  assign busy             = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_stored_index = out_idx_r;
  assign out_pixel_color  = out_col_r;

endmodule

>>> hw/rtl/pif_checker.sv
`include "palette_indexed_framebuffer_assert.svh"

module pif_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_command,
  input logic        out_valid
);

  logic rd_beat;
  logic wr_beat;

  assign rd_beat = start && !busy && (in_command == pif_pkg::CMD_READ);
  assign wr_beat = start && !busy && (in_command == pif_pkg::CMD_WRITE);

  // a read beat yields its result once the pixel and palette reads are through
  `PIF_ASSERT_NOW(a_read_result, rd_beat, ##3 out_valid, "read beat without result")
  // read and write hold the block while the pixel memory is in use
  `PIF_ASSERT_NEXT(a_read_busy, rd_beat || wr_beat, busy, "block not busy after read or write")
  // results never come back to back
  `PIF_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid, "result strobe held two cycles")
  // the block is free again when a result shows
  `PIF_ASSERT_NOW(a_idle_on_result, out_valid, !busy, "busy while result shown")

endmodule

bind palette_indexed_framebuffer pif_checker u_pif_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_command (in_command),
  .out_valid  (out_valid)
);

>>> tb/palette_indexed_framebuffer_tb.sv
module palette_indexed_framebuffer_tb;

  // one command beat as the sender sees it, with the read result it must produce
  typedef struct packed {
    logic [3:0]  idx;
    logic [15:0] rgb;
  } pixel_read_t;

  typedef struct packed {
    pif_pkg::cmd_t cmd;
    logic [6:0]    x;
    logic [5:0]    y;
    logic [3:0]    ci;
    logic [15:0]   rgb;
    logic          drain;   // hold this beat back until every read result is in
    logic          gaps;    // sender may idle in front of this beat
    pixel_read_t   want;
  } fb_cmd_t;

  localparam int NUM_PIXELS = pif_pkg::AREA_WIDTH * pif_pkg::AREA_HEIGHT;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_command = pif_pkg::CMD_WRITE;
  logic [6:0]  in_x = '0;
  logic [5:0]  in_y = '0;
  logic [3:0]  in_color_index = '0;
  logic [15:0] in_palette_color = '0;
  logic        out_valid;
  logic [3:0]  out_stored_index;
  logic [15:0] out_pixel_color;

  palette_indexed_framebuffer u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_command       (in_command),
    .in_x             (in_x),
    .in_y             (in_y),
    .in_color_index   (in_color_index),
    .in_palette_color (in_palette_color),
    .out_valid        (out_valid),
    .out_stored_index (out_stored_index),
    .out_pixel_color  (out_pixel_color)
  );

  always #1 clk = ~clk;

  // shadow framebuffer, advanced in command order as beats are queued
  logic [7:0]  shadow_pix [pif_pkg::STORE_BYTES];
  logic [15:0] shadow_pal [16];
  logic [4:0]  shadow_cnt = '0;
  bit          pix_known [NUM_PIXELS];
  bit          pal_known [16];

  fb_cmd_t     cmd_backlog [$];   // beats waiting for the driver
  pixel_read_t reads_due [$];     // read results owed by the block
  fb_cmd_t     cur_cmd;
  pixel_read_t got_read;

  int errors = 0;
  int reads_checked = 0;
  int beats_by_cmd [4] = '{0, 0, 0, 0};
  bit next_drain = 1'b0;
  bit gaps_on = 1'b1;

  // framebuffer behavior: applies one command, returns what a read would give
  function automatic pixel_read_t fb_apply(fb_cmd_t c);
    int          off;
    logic [7:0]  b;
    pixel_read_t r;
    r = '0;
    off = int'(c.y) * pif_pkg::AREA_WIDTH + int'(c.x);
    case (c.cmd)
      pif_pkg::CMD_WRITE: begin
        if (c.x < pif_pkg::AREA_WIDTH && c.y < pif_pkg::AREA_HEIGHT) begin
          b = shadow_pix[off >> 1];
          if (off[0]) b[7:4] = c.ci;
          else b[3:0] = c.ci;
          shadow_pix[off >> 1] = b;
          pix_known[off] = 1'b1;
        end
      end
      pif_pkg::CMD_READ: begin
        if (c.x < pif_pkg::AREA_WIDTH && c.y < pif_pkg::AREA_HEIGHT) begin
          b = shadow_pix[off >> 1];
          r.idx = off[0] ? b[7:4] : b[3:0];
          r.rgb = ({1'b0, r.idx} < shadow_cnt) ? shadow_pal[r.idx] : pif_pkg::BLACK;
        end
      end
      pif_pkg::CMD_PALETTE: begin
        if (c.ci < pif_pkg::PALETTE_SIZE) begin
          shadow_pal[c.ci] = c.rgb;
          pal_known[c.ci] = 1'b1;
          if ({1'b0, c.ci} >= shadow_cnt) shadow_cnt = {1'b0, c.ci} + 5'd1;
        end
      end
      default: begin
        // clear fills every byte with the colour index in both nibbles
        for (int i = 0; i < pif_pkg::STORE_BYTES; i++) shadow_pix[i] = {c.ci, c.ci};
        for (int i = 0; i < NUM_PIXELS; i++) pix_known[i] = 1'b1;
      end
    endcase
    return r;
  endfunction

  // a read is only legal on a written pixel whose palette entry is defined or past the count
  function automatic bit read_ok(logic [6:0] x, logic [5:0] y);
    int         off;
    logic [7:0] b;
    logic [3:0] idx;
    off = int'(y) * pif_pkg::AREA_WIDTH + int'(x);
    if (!pix_known[off]) return 1'b0;
    b = shadow_pix[off >> 1];
    idx = off[0] ? b[7:4] : b[3:0];
    return ({1'b0, idx} >= shadow_cnt) || pal_known[idx];
  endfunction

  task automatic queue_cmd(pif_pkg::cmd_t cmd, logic [6:0] x, logic [5:0] y,
                           logic [3:0] ci, logic [15:0] rgb);
    fb_cmd_t c;
    c.cmd = cmd;
    c.x = x;
    c.y = y;
    c.ci = ci;
    c.rgb = rgb;
    c.drain = next_drain;
    c.gaps = gaps_on;
    c.want = fb_apply(c);
    next_drain = 1'b0;
    cmd_backlog.push_back(c);
  endtask

  // driver: presents the next beat once the current one is taken
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        beats_by_cmd[cur_cmd.cmd] = beats_by_cmd[cur_cmd.cmd] + 1;
        if (cur_cmd.cmd == pif_pkg::CMD_READ) reads_due.push_back(cur_cmd.want);
      end
      if (!(start && busy)) begin
        if (cmd_backlog.size() != 0
            && !(cmd_backlog[0].drain && reads_due.size() != 0)
            && !(cmd_backlog[0].gaps && $urandom_range(99) < 17)) begin
          cur_cmd = cmd_backlog.pop_front();
          start <= 1'b1;
          in_command <= cur_cmd.cmd;
          in_x <= cur_cmd.x;
          in_y <= cur_cmd.y;
          in_color_index <= cur_cmd.ci;
          in_palette_color <= cur_cmd.rgb;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: every strobed read beat is matched against the oldest read owed
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (reads_due.size() == 0) begin
        $error("read beat with none owed: stored_index %0h pixel_color %04h",
               out_stored_index, out_pixel_color);
        errors++;
      end else begin
        got_read = reads_due.pop_front();
        reads_checked++;
        if (out_stored_index !== got_read.idx) begin
          $error("stored_index: expected %0h, actual %0h", got_read.idx, out_stored_index);
          errors++;
        end
        if (out_pixel_color !== got_read.rgb) begin
          $error("pixel_color: expected %04h, actual %04h", got_read.rgb, out_pixel_color);
          errors++;
        end
      end
    end
  end

  // stimulus and end of run
  initial begin : stim
    logic [6:0]  rx, last_x;
    logic [5:0]  ry, last_y;
    logic [3:0]  rci;
    logic [15:0] rrgb;
    int          pick;
    bit          found;
    last_x = '0;
    last_y = '0;

    // directed: palette count zero, nibble packing, count edges, overwrite, clear
    queue_cmd(pif_pkg::CMD_WRITE, 7'd0, 6'd0, 4'h5, 16'h0000);
    queue_cmd(pif_pkg::CMD_READ, 7'd0, 6'd0, 4'h0, 16'h0000);       // count still zero: black
    queue_cmd(pif_pkg::CMD_CLEAR, 7'd0, 6'd0, 4'hA, 16'h0000);
    queue_cmd(pif_pkg::CMD_READ, 7'd127, 6'd63, 4'h0, 16'h0000);    // last pixel, high nibble
    queue_cmd(pif_pkg::CMD_PALETTE, 7'd0, 6'd0, 4'h0, 16'hFFFF);
    queue_cmd(pif_pkg::CMD_PALETTE, 7'd0, 6'd0, 4'h1, 16'h0000);
    queue_cmd(pif_pkg::CMD_WRITE, 7'd1, 6'd0, 4'h0, 16'hFFFF);
    queue_cmd(pif_pkg::CMD_READ, 7'd1, 6'd0, 4'hF, 16'h0000);
    queue_cmd(pif_pkg::CMD_WRITE, 7'd127, 6'd63, 4'hF, 16'h0000);
    queue_cmd(pif_pkg::CMD_READ, 7'd126, 6'd63, 4'h0, 16'h0000);    // index past count: black
    queue_cmd(pif_pkg::CMD_PALETTE, 7'd0, 6'd0, 4'hA, 16'hA5A5);    // count jumps to 11
    queue_cmd(pif_pkg::CMD_READ, 7'd126, 6'd63, 4'h0, 16'h0000);
    queue_cmd(pif_pkg::CMD_PALETTE, 7'd127, 6'd63, 4'hF, 16'h5A5A); // top entry, count 16
    queue_cmd(pif_pkg::CMD_READ, 7'd127, 6'd63, 4'h0, 16'h0000);
    queue_cmd(pif_pkg::CMD_WRITE, 7'd0, 6'd0, 4'h1, 16'h0000);
    queue_cmd(pif_pkg::CMD_READ, 7'd1, 6'd0, 4'h0, 16'h0000);       // neighbor nibble intact
    queue_cmd(pif_pkg::CMD_READ, 7'd0, 6'd0, 4'h0, 16'h0000);
    queue_cmd(pif_pkg::CMD_PALETTE, 7'd0, 6'd0, 4'h1, 16'h8001);    // overwrite below count
    queue_cmd(pif_pkg::CMD_READ, 7'd0, 6'd0, 4'h0, 16'h0000);
    queue_cmd(pif_pkg::CMD_CLEAR, 7'd0, 6'd0, 4'h0, 16'h0000);
    queue_cmd(pif_pkg::CMD_READ, 7'd64, 6'd32, 4'h0, 16'h0000);

    // random traffic; reads lean on recently written pixels
    for (int i = 0; i < 1330; i++) begin
      gaps_on = !(i >= 500 && i < 800);
      if (i % 250 == 0) next_drain = 1'b1;
      pick = $urandom_range(99);
      rx = 7'($urandom_range(127));
      ry = 6'($urandom_range(63));
      rci = 4'($urandom_range(15));
      rrgb = 16'($urandom_range(65535));
      if ($urandom_range(9) == 0) rrgb = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      if (pick < 2) begin
        queue_cmd(pif_pkg::CMD_CLEAR, rx, ry, rci, rrgb);
      end else if (pick < 40) begin
        queue_cmd(pif_pkg::CMD_WRITE, rx, ry, rci, rrgb);
        last_x = rx;
        last_y = ry;
      end else if (pick < 50) begin
        // mostly fill the palette without leaving undefined entries
        if ($urandom_range(99) < 70)
          rci = 4'($urandom_range(shadow_cnt > 5'd15 ? 15 : int'(shadow_cnt)));
        queue_cmd(pif_pkg::CMD_PALETTE, rx, ry, rci, rrgb);
      end else begin
        if ($urandom_range(1)) begin
          rx = last_x;
          ry = last_y;
        end
        found = read_ok(rx, ry);
        for (int t = 0; t < 8 && !found; t++) begin
          rx = 7'($urandom_range(127));
          ry = 6'($urandom_range(63));
          found = read_ok(rx, ry);
        end
        if (found) queue_cmd(pif_pkg::CMD_READ, rx, ry, rci, rrgb);
        else queue_cmd(pif_pkg::CMD_WRITE, rx, ry, rci, rrgb);
      end
    end

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (cmd_backlog.size() != 0 || start || reads_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("beats: %0d write, %0d read, %0d palette, %0d clear",
             beats_by_cmd[pif_pkg::CMD_WRITE], beats_by_cmd[pif_pkg::CMD_READ],
             beats_by_cmd[pif_pkg::CMD_PALETTE], beats_by_cmd[pif_pkg::CMD_CLEAR]);
    $display("read beats checked: %0d, mismatches: %0d", reads_checked, errors);
    if (errors == 0 && reads_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hang guard, far above the clear-heavy worst case
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

endmodule
